FILE: hw/rtl/wht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wht_pkg
// Shared widths, opcodes, result kinds and sequencer states of the
// Walsh-Hadamard transform unit.
// ----------------------------------------------------------------------------
package wht_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 10;
    localparam int WORD_W   = 64;
    localparam int LOG_W    = 4;

    localparam logic [LOG_W-1:0] LOG_SIZE_RESET = 4'd10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_BF_READ,
        S_BF_WLO,
        S_BF_WHI
    } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wht_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wht_if
// Valid/ready channels of the transform unit: request items, response items
// and configuration writes.
// ----------------------------------------------------------------------------
interface wht_req_if import wht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  index;
    logic [WORD_W-1:0]   value;

    modport source (output valid, output opcode, output index, output value, input ready);
    modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

interface wht_rsp_if import wht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] data;

    modport source (output valid, output kind, output data, input ready);
    modport sink   (input valid, input kind, input data, output ready);
endinterface

interface wht_cfg_if import wht_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LOG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/walsh_hadamard_transform_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Write item: taken in S_IDLE, one every cycle while idle. Read item: the word passes
// the store's read register, then the response register. Transform item: a read, a low
// write and a high write per butterfly, L * 2^(L-1) butterflies for L = log_size capped
// at MAX_LOG_SIZE; set by the single write port of the word store (two writes per butterfly).
// Reset clears the sequencer, the response slot and sets log_size to 10; the word
// store keeps no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// walsh_hadamard_transform_unit
// In-place unnormalised fast Walsh-Hadamard transform over a 64-bit word store,
// with word write and read items and a transform command.
// ----------------------------------------------------------------------------
module walsh_hadamard_transform_unit import wht_pkg::*; #(
    parameter int MAX_LOG_SIZE = 10
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wht_req_if.sink    req,
    wht_rsp_if.source  rsp,
    wht_cfg_if.sink    cfg
);

    localparam int AW    = MAX_LOG_SIZE;
    localparam int DEPTH = 1 << MAX_LOG_SIZE;
    localparam int PW    = $clog2(MAX_LOG_SIZE + 1);

    logic [WORD_W-1:0] store_mem [DEPTH];

    state_t            state_reg, state_next;
    logic [LOG_W-1:0]  log_size_reg;
    logic [PW-1:0]     pass_reg, pass_next;
    logic [AW-1:0]     bfly_reg, bfly_next;
    logic [WORD_W-1:0] diff_reg, diff_next;
    logic [WORD_W-1:0] rd_a_reg, rd_b_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     rd_a_addr, rd_b_addr;

    logic [PW-1:0]     eff_log;
    logic [AW-1:0]     req_addr;
    logic [AW-1:0]     bit_p, low_mask, bfly_lo, bfly_hi, half_cnt;
    logic              slot_free, last_bfly, last_pass;

    assign eff_log   = (32'(log_size_reg) > MAX_LOG_SIZE) ? PW'(MAX_LOG_SIZE)
                                                           : PW'(log_size_reg);
    assign req_addr  = AW'(req.index);
    assign bit_p     = AW'(1) << pass_reg;
    assign low_mask  = bit_p - AW'(1);
    assign bfly_lo   = ((bfly_reg & ~low_mask) << 1) | (bfly_reg & low_mask);
    assign bfly_hi   = bfly_lo | bit_p;
    assign half_cnt  = AW'(1) << PW'(eff_log - PW'(1));
    assign last_bfly = (bfly_reg == (half_cnt - AW'(1)));
    assign last_pass = (pass_reg == PW'(eff_log - PW'(1)));
    assign slot_free = !out_valid_reg || rsp.ready;

    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.kind  = out_kind_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        bfly_next      = bfly_reg;
        diff_next      = diff_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        req.ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = req_addr;
        mem_wdata      = req.value;
        rd_a_addr      = (state_reg == S_IDLE) ? req_addr : bfly_lo;
        rd_b_addr      = bfly_hi;

        unique case (state_reg)
            S_IDLE:
            begin
                unique case (op_t'(req.opcode)) inside
                    OP_READ, OP_RUN: req.ready = slot_free;
                    default:         req.ready = 1'b1;
                endcase
                if (req.valid && req.ready)
                begin
                    unique case (op_t'(req.opcode))
                        OP_WRITE: mem_we = 1'b1;
                        OP_READ:  state_next = S_RD_WAIT;
                        OP_RUN:
                        begin
                            if (eff_log == PW'(0))
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_DONE;
                                out_data_next  = '0;
                            end
                            else
                            begin
                                pass_next  = '0;
                                bfly_next  = '0;
                                state_next = S_BF_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_READ;
                out_data_next  = rd_a_reg;
                state_next     = S_IDLE;
            end
            S_BF_READ:
            begin
                state_next = S_BF_WLO;
            end
            S_BF_WLO:
            begin
                mem_we     = 1'b1;
                mem_waddr  = bfly_lo;
                mem_wdata  = rd_a_reg + rd_b_reg;
                diff_next  = rd_a_reg - rd_b_reg;
                state_next = S_BF_WHI;
            end
            S_BF_WHI:
            begin
                mem_we     = 1'b1;
                mem_waddr  = bfly_hi;
                mem_wdata  = diff_reg;
                state_next = S_BF_READ;
                if (last_bfly)
                begin
                    bfly_next = '0;
                    if (last_pass)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_DONE;
                        out_data_next  = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        pass_next = pass_reg + PW'(1);
                    end
                end
                else
                begin
                    bfly_next = bfly_reg + AW'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            log_size_reg  <= LOG_SIZE_RESET;
            pass_reg      <= '0;
            bfly_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            bfly_reg      <= bfly_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                log_size_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= store_mem[rd_a_addr];
        rd_b_reg <= store_mem[rd_b_addr];
    end

endmodule
`default_nettype wire
